// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/lcs_pkg.sv =====
// Types and constants shared by the LCS row engine.
package lcs_pkg;

  localparam int MaxB    = 256;
  localparam int SymBits = 8;
  localparam int PosW    = 9;
  localparam int RowW    = 9;

  typedef enum logic [1:0] {
    ReqStart = 2'd0,
    ReqLoad  = 2'd1,
    ReqProc  = 2'd2,
    ReqRead  = 2'd3
  } req_e;

  typedef struct packed {
    req_e        req_type;
    logic [8:0]  position;
    logic [7:0]  symbol;
    logic [8:0]  b_length;
  } in_word_t;

  typedef struct packed {
    logic [8:0]  row_value;
    logic        out_of_range;
  } out_word_t;

  // Word traveling down the row of cells, one cell per cycle while the row advances.
  typedef struct packed {
    logic               valid;
    req_e               req;
    logic [PosW-1:0]    pos;
    logic [SymBits-1:0] sym;
    logic [PosW-1:0]    n;
    logic [RowW-1:0]    left;
    logic [RowW-1:0]    diag;
    logic [RowW-1:0]    value;
    logic               flag;
  } tok_t;

endpackage

// ===== rtl/lcs_cell.sv =====
// One cell of the row: holds B symbol idx-1 and row entry idx.
module lcs_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [lcs_pkg::PosW-1:0]   idx_i,
  input  lcs_pkg::tok_t              tok_i,
  output lcs_pkg::tok_t              tok_o
);
  import lcs_pkg::*;

  logic [SymBits-1:0] b_sym_q;
  logic [RowW-1:0]    row_q, row_d;
  tok_t               tok_q, tok_d;
  logic [RowW-1:0]    cand;
  logic               active;
  logic               read_hit;
  logic               load_hit;

  assign active   = (idx_i <= tok_i.n);
  assign read_hit = (tok_i.pos == idx_i) && !tok_i.flag;
  // Cell idx holds B symbol idx-1, so a load at position p lands in cell p+1.
  assign load_hit = tok_i.valid && (tok_i.req == ReqLoad) && !tok_i.flag &&
                    (({1'b0, tok_i.pos} + (PosW+1)'(1)) == {1'b0, idx_i});

  always_comb begin
    tok_d = tok_i;
    row_d = row_q;
    if (tok_i.sym == b_sym_q) begin
      cand = RowW'(tok_i.diag + 1'b1);
    end else begin
      cand = (tok_i.left > row_q) ? tok_i.left : row_q;
    end
    if (tok_i.valid) begin
      case (tok_i.req)
        ReqStart: begin
          row_d = '0;
        end
        ReqProc: begin
          if (active) begin
            row_d      = cand;
            tok_d.left = cand;
            tok_d.diag = row_q;
            if (idx_i == tok_i.n) begin
              tok_d.value = cand;
            end
          end
        end
        ReqRead: begin
          if (read_hit) begin
            tok_d.value = row_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      tok_q <= '0;
    end else if (adv_i) begin
      row_q <= row_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && load_hit) begin
      b_sym_q <= tok_i.sym;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/lcs_length_row_top.sv =====
// Top level of the linear-space LCS length engine: a systolic row of cells.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid_i/in_stall_o | lcs_pkg::in_word_t
//   out     | output    | out_valid_o/out_stall_i | lcs_pkg::out_word_t
//
// Every word walks the row of MaxB cells, one cell per cycle while the row advances, and
// its result leaves the last cell; a new word may enter every cycle that the row advances.
// Each A symbol sweeps the row as a wavefront behind the one before, one cell per unstalled cycle.
// Reset clears every row entry and the B length; B symbols are unknown until loaded.
// A stalled result freezes the whole row, and the input is stalled with it.
module lcs_length_row_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcs_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcs_pkg::out_word_t  out_data_o
);
  import lcs_pkg::*;

  logic            adv;
  logic            in_acc;
  logic [PosW-1:0] b_count_q, b_count_d;
  logic [PosW-1:0] n_new;
  tok_t            tok_in;
  tok_t            tok_w [MaxB+1];

  assign adv        = !(tok_w[MaxB].valid && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  assign n_new = (in_data_i.b_length > PosW'(MaxB)) ? PosW'(MaxB) : in_data_i.b_length;

  always_comb begin
    b_count_d = b_count_q;
    if (in_acc && (in_data_i.req_type == ReqStart)) begin
      b_count_d = n_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_count_q <= '0;
    end else begin
      b_count_q <= b_count_d;
    end
  end

  // Range flags and the length are settled here so the cells only compare indexes.
  always_comb begin
    tok_in.valid = in_acc;
    tok_in.req   = in_data_i.req_type;
    tok_in.pos   = in_data_i.position;
    tok_in.sym   = in_data_i.symbol[SymBits-1:0];
    tok_in.n     = (in_data_i.req_type == ReqStart) ? n_new : b_count_q;
    tok_in.left  = '0;
    tok_in.diag  = '0;
    tok_in.value = '0;
    tok_in.flag  =
      ((in_data_i.req_type == ReqLoad) && (in_data_i.position >= b_count_q)) ||
      ((in_data_i.req_type == ReqRead) && (in_data_i.position > b_count_q));
  end

  assign tok_w[0] = tok_in;

  for (genvar k = 0; k < MaxB; k++) begin : g_cell
    lcs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .idx_i  (PosW'(k + 1)),
      .tok_i  (tok_w[k]),
      .tok_o  (tok_w[k+1])
    );
  end

  assign out_valid_o             = tok_w[MaxB].valid;
  assign out_data_o.row_value    = tok_w[MaxB].value;
  assign out_data_o.out_of_range = tok_w[MaxB].flag;

endmodule

// ===== rtl/lcs_chk.sv =====
// Port-level checker for the LCS row engine, bound to its top level.
`include "assert_macros.svh"

module lcs_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input lcs_pkg::in_word_t   in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lcs_pkg::out_word_t  out_data_o
);
  import lcs_pkg::*;

  // A stalled input word stays up and unchanged.
  `ASSERT_CLK(a_in_hold, clk_i, rst_ni,
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_data_i)))

  // A waiting result stays up and unchanged.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))

  // The input is held back exactly while a result is stuck at the output.
  `ASSERT_CLK(a_in_stall, clk_i, rst_ni,
    in_stall_o == (out_valid_o && out_stall_i))

  // A flagged word never carries a row value.
  `ASSERT_NEVER(a_flag_zero, clk_i, rst_ni,
    out_valid_o && out_data_o.out_of_range && (out_data_o.row_value != '0))

  // No LCS length exceeds the longest B sequence.
  `ASSERT_NEVER(a_value_max, clk_i, rst_ni,
    out_valid_o && (out_data_o.row_value > RowW'(MaxB)))

endmodule

bind lcs_length_row_top lcs_chk u_lcs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
